// ----- hdl/amg_pkg.sv -----
// Shared types and constants for the affine transform matrix generator.
// No dependencies.
package amg_pkg;

  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_SCALE     = 3'd1;
  localparam logic [2:0] OP_ROT_X     = 3'd2;
  localparam logic [2:0] OP_ROT_Y     = 3'd3;
  localparam logic [2:0] OP_ROT_Z     = 3'd4;
  localparam logic [2:0] OP_AXIS      = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] angle;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
    logic               trig;
  } item_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: return 32'd843314856;
      5'd1: return 32'd497837829;
      5'd2: return 32'd263043836;
      5'd3: return 32'd133525158;
      5'd4: return 32'd67021686;
      5'd5: return 32'd33543515;
      5'd6: return 32'd16775850;
      5'd7: return 32'd8388437;
      5'd8: return 32'd4194282;
      5'd9: return 32'd2097149;
      default: return 32'd1 << (5'd30 - i);
    endcase
  endfunction

endpackage

// ----- hdl/amg_front.sv -----
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
// Depends on amg_pkg.
module amg_front import amg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic signed [31:0] angle,
  input  logic signed [31:0] val_x,
  input  logic signed [31:0] val_y,
  input  logic signed [31:0] val_z,
  output logic               busy,
  output logic               head_valid,
  output item_t              head,
  input  logic               pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: op, angle: angle, val_x: val_x, val_y: val_y, val_z: val_z,
                       trig: (op == OP_ROT_X) || (op == OP_ROT_Y) ||
                             (op == OP_ROT_Z) || (op == OP_AXIS)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/amg_back.sv -----
// Back end: range reduction, CORDIC, axis normalisation and row output sequencing.
// Depends on amg_pkg.
module amg_back import amg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  item_t              head,
  output logic               pop,
  output logic               row_valid,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               zero_axis,
  output logic               last_row
);

  localparam logic [45:0] TWO_PI  = 46'd6746518852;
  localparam logic signed [34:0] PI_S    = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_S = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] GAIN    = 34'sd652032874;
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_FOLD, S_CORDIC, S_SC, S_SQ, S_CHK, S_SQRT, S_DIVI, S_DIVS, S_MUL, S_EMIT
  } state_t;

  function automatic logic signed [31:0] rnd_sat(input logic signed [64:0] v, input int frac);
    logic signed [64:0] r;
    r = (v + (65'sd1 <<< (frac - 1))) >>> frac;
    if (r > 65'sd2147483647) return 32'sh7fffffff;
    if (r < -65'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  state_t             state;
  logic [1:0]         row;
  logic [4:0]         cnt;
  logic [1:0]         comp;
  logic [2:0]         op;
  logic signed [31:0] vec [3];
  logic               zero;
  logic [45:0]        rem;
  logic               aneg;
  logic signed [33:0] cx, cy;
  logic signed [34:0] cr;
  logic               flip;
  logic signed [34:0] c30;
  logic signed [33:0] s30;
  logic signed [31:0] c16, s16;
  logic [63:0]        sum;
  logic [63:0]        sq_n, sq_res;
  logic [61:0]        dvd;
  logic [31:0]        drem;
  logic [30:0]        quo;
  logic signed [32:0] u [3];
  logic signed [32:0] qp [6];
  logic signed [63:0] pd [6];
  logic signed [63:0] ps [3];

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [34:0] tq;
  logic [45:0]        tp;
  logic signed [34:0] r0, r1;
  logic signed [33:0] sx, sy;
  logic [63:0]        sbit;
  logic [32:0]        rem2;
  logic               ge;
  logic [30:0]        quo_n;
  logic [31:0]        len;
  logic [31:0]        dmag;
  logic signed [34:0] c30_v;
  logic signed [63:0] cq;
  logic signed [63:0] ea [3], eb [3];
  logic signed [31:0] cv [4];
  logic signed [31:0] rs [3];

  assign pop = head_valid && (state == S_IDLE || (state == S_EMIT && row == 2'd3));
  assign prod = ma * mb;
  assign tq = ONE_Q30 - c30;
  assign tp = TWO_PI << cnt;
  assign sx = cx >>> cnt;
  assign sy = cy >>> cnt;
  assign sbit = 64'd1 << {cnt, 1'b0};
  assign len = sq_res[31:0];
  assign rem2 = {drem, dvd[{1'b0, cnt}]};
  assign ge = rem2 >= {1'b0, len};
  assign quo_n = quo | (31'(ge) << cnt);
  assign dmag = absv(vec[comp]);
  assign c30_v = flip ? -{cx[33], cx} : {cx[33], cx};
  assign cq = 64'(c30) <<< 30;

  always_comb begin
    r0 = (aneg && rem[32:0] != 33'd0) ? TWO_PI_S - $signed({2'b0, rem[32:0]})
                                      : $signed({2'b0, rem[32:0]});
    if (r0 > PI_S) r0 = r0 - TWO_PI_S;
    r1 = r0;
    if (r0 > HALF_PI) r1 = PI_S - r0;
    else if (r0 < -HALF_PI) r1 = -PI_S - r0;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQ: begin
        ma = $signed({2'b0, absv(vec[comp])});
        mb = ma;
      end
      S_MUL: begin
        case (cnt)
          5'd0: begin ma = 34'(u[0]); mb = 34'(u[0]); end
          5'd1: begin ma = 34'(u[1]); mb = 34'(u[1]); end
          5'd2: begin ma = 34'(u[2]); mb = 34'(u[2]); end
          5'd3: begin ma = 34'(u[0]); mb = 34'(u[1]); end
          5'd4: begin ma = 34'(u[0]); mb = 34'(u[2]); end
          5'd5: begin ma = 34'(u[1]); mb = 34'(u[2]); end
          5'd6: begin ma = 34'(qp[0]); mb = tq[33:0]; end
          5'd7: begin ma = 34'(qp[1]); mb = tq[33:0]; end
          5'd8: begin ma = 34'(qp[2]); mb = tq[33:0]; end
          5'd9: begin ma = 34'(qp[3]); mb = tq[33:0]; end
          5'd10: begin ma = 34'(qp[4]); mb = tq[33:0]; end
          5'd11: begin ma = 34'(qp[5]); mb = tq[33:0]; end
          5'd12: begin ma = 34'(u[0]); mb = s30; end
          5'd13: begin ma = 34'(u[1]); mb = s30; end
          5'd14: begin ma = 34'(u[2]); mb = s30; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    case (row)
      2'd0: begin
        ea[0] = pd[0]; eb[0] = cq;
        ea[1] = pd[3]; eb[1] = -ps[2];
        ea[2] = pd[4]; eb[2] = ps[1];
      end
      2'd1: begin
        ea[0] = pd[3]; eb[0] = ps[2];
        ea[1] = pd[1]; eb[1] = cq;
        ea[2] = pd[5]; eb[2] = -ps[0];
      end
      default: begin
        ea[0] = pd[4]; eb[0] = -ps[1];
        ea[1] = pd[5]; eb[1] = ps[0];
        ea[2] = pd[2]; eb[2] = cq;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      rs[k] = rnd_sat(65'(ea[k]) + 65'(eb[k]), 44);
    end
    for (int k = 0; k < 4; k++) begin
      cv[k] = (2'(k) == row) ? ONE_Q16 : 32'sd0;
    end
    case (op)
      OP_TRANSLATE: begin
        if (row != 2'd3) cv[3] = vec[row];
      end
      OP_SCALE: begin
        if (row != 2'd3) cv[row] = vec[row];
      end
      OP_ROT_X: begin
        if (row == 2'd1) begin cv[1] = c16; cv[2] = -s16; end
        if (row == 2'd2) begin cv[1] = s16; cv[2] = c16; end
      end
      OP_ROT_Y: begin
        if (row == 2'd0) begin cv[0] = c16; cv[2] = s16; end
        if (row == 2'd2) begin cv[0] = -s16; cv[2] = c16; end
      end
      OP_ROT_Z: begin
        if (row == 2'd0) begin cv[0] = c16; cv[1] = -s16; end
        if (row == 2'd1) begin cv[0] = s16; cv[1] = c16; end
      end
      OP_AXIS: begin
        if (!zero && row != 2'd3) begin
          cv[0] = rs[0];
          cv[1] = rs[1];
          cv[2] = rs[2];
        end
      end
      default: begin
        cv[0] = cv[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= 2'd0;
      row_valid <= 1'b0;
      last_row  <= 1'b0;
      zero_axis <= 1'b0;
      row_index <= 2'd0;
    end else begin
      row_valid <= 1'b0;
      last_row  <= 1'b0;
      case (state)
        S_IDLE: begin
        end
        S_RED: begin
          if (rem >= tp) rem <= rem - tp;
          if (cnt == 5'd0) state <= S_FOLD;
          else cnt <= cnt - 5'd1;
        end
        S_FOLD: begin
          cr    <= r1;
          flip  <= (r0 > HALF_PI) || (r0 < -HALF_PI);
          cx    <= GAIN;
          cy    <= '0;
          cnt   <= 5'd0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cr[34]) begin
            cx <= cx - sy;
            cy <= cy + sx;
            cr <= cr - $signed({3'b0, atan_q30(cnt)});
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            cr <= cr + $signed({3'b0, atan_q30(cnt)});
          end
          if (cnt == LAST_STEP) state <= S_SC;
          else cnt <= cnt + 5'd1;
        end
        S_SC: begin
          c30  <= c30_v;
          s30  <= cy;
          c16  <= rnd_sat(65'(c30_v), 14);
          s16  <= rnd_sat(65'(cy), 14);
          sum  <= '0;
          comp <= 2'd0;
          row  <= 2'd0;
          state <= (op == OP_AXIS) ? S_SQ : S_EMIT;
        end
        S_SQ: begin
          sum <= sum + prod[63:0];
          if (comp == 2'd2) state <= S_CHK;
          else comp <= comp + 2'd1;
        end
        S_CHK: begin
          if (sum == 64'd0) begin
            zero  <= 1'b1;
            row   <= 2'd0;
            state <= S_EMIT;
          end else begin
            sq_n   <= sum;
            sq_res <= '0;
            cnt    <= 5'd31;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_n >= sq_res + sbit) begin
            sq_n   <= sq_n - (sq_res + sbit);
            sq_res <= (sq_res >> 1) + sbit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          if (cnt == 5'd0) begin
            comp  <= 2'd0;
            state <= S_DIVI;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_DIVI: begin
          dvd   <= ({30'd0, dmag} << 30) + 62'(len >> 1);
          drem  <= 32'((({30'd0, dmag} << 30) + 62'(len >> 1)) >> 31);
          quo   <= '0;
          cnt   <= 5'd30;
          state <= S_DIVS;
        end
        S_DIVS: begin
          drem <= ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
          quo  <= quo_n;
          if (cnt == 5'd0) begin
            u[comp] <= vec[comp][31] ? -$signed({2'b0, quo_n}) : $signed({2'b0, quo_n});
            if (comp == 2'd2) begin
              cnt   <= 5'd0;
              state <= S_MUL;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIVI;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_MUL: begin
          case (cnt)
            5'd0: qp[0] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd1: qp[1] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd2: qp[2] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd3: qp[3] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd4: qp[4] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd5: qp[5] <= 33'((prod + 68'sd536870912) >>> 30);
            5'd6: pd[0] <= prod[63:0];
            5'd7: pd[1] <= prod[63:0];
            5'd8: pd[2] <= prod[63:0];
            5'd9: pd[3] <= prod[63:0];
            5'd10: pd[4] <= prod[63:0];
            5'd11: pd[5] <= prod[63:0];
            5'd12: ps[0] <= prod[63:0];
            5'd13: ps[1] <= prod[63:0];
            default: ps[2] <= prod[63:0];
          endcase
          if (cnt == 5'd14) begin
            row   <= 2'd0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_EMIT: begin
          row_valid <= 1'b1;
          row_index <= row;
          col0      <= cv[0];
          col1      <= cv[1];
          col2      <= cv[2];
          col3      <= cv[3];
          zero_axis <= zero;
          last_row  <= (row == 2'd3);
          row       <= row + 2'd1;
          if (row == 2'd3) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (pop) begin
        op     <= head.op;
        vec[0] <= head.val_x;
        vec[1] <= head.val_y;
        vec[2] <= head.val_z;
        zero   <= 1'b0;
        aneg   <= head.angle[31];
        rem    <= {absv(head.angle), 14'd0};
        row    <= 2'd0;
        cnt    <= 5'd12;
        state  <= head.trig ? S_RED : S_EMIT;
      end
    end
  end

endmodule

// ----- hdl/affine_transform_matrix_generator.sv -----
// For translate, scale and unused codes row 0 follows straight from the queue; rotations
// first pass range reduction and CORDIC, axis-angle also square root, divides and products.
// Matrices for translate and scale run back to back, bound by the four row outputs; rotation
// work is bound by the shared CORDIC, square-root and divide iterations.
// A two-entry command queue holds further commands; busy is high while it is full.
// Reset is synchronous and clears the queue and sequencer; no state survives between items.
module affine_transform_matrix_generator import amg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] angle,
  input  logic signed [31:0] val_x,
  input  logic signed [31:0] val_y,
  input  logic signed [31:0] val_z,
  output logic               row_valid,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               zero_axis,
  output logic               last_row
);

  item_t head;
  logic  head_valid;
  logic  pop;

  amg_front u_front (
    .clk(clk), .rst(rst), .start(start), .op(op), .angle(angle),
    .val_x(val_x), .val_y(val_y), .val_z(val_z), .busy(busy),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  amg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .row_valid(row_valid), .row_index(row_index), .col0(col0), .col1(col1),
    .col2(col2), .col3(col3), .zero_axis(zero_axis), .last_row(last_row)
  );

endmodule

// ----- hdl/amg_checker.sv -----
// Port-level checks on the row output sequence of the matrix generator.
// Bound to affine_transform_matrix_generator; no package dependency.
module amg_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       row_valid,
  input logic [1:0] row_index,
  input logic       zero_axis,
  input logic       last_row
);

  a_rows_consecutive: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_index != 2'd0 |-> $past(row_valid) && $past(row_index) == row_index - 2'd1)
    else $error("row results not consecutive");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> last_row == (row_index == 2'd3))
    else $error("last_row does not match row_index");

  a_zero_steady: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_index != 2'd0 |-> zero_axis == $past(zero_axis))
    else $error("zero_axis changed within a matrix");

  a_new_matrix: assert property (@(posedge clk) disable iff (rst)
    row_valid && $past(row_valid) && !$past(last_row) |-> row_index != 2'd0)
    else $error("matrix started before previous finished");

  a_free_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !busy)
    else $error("busy high after reset");

endmodule

bind affine_transform_matrix_generator amg_checker u_amg_checker (.*);

// ----- tb/sv/affine_transform_matrix_generator_tb.sv -----
// Self-checking testbench for the affine transform matrix generator.
// Depends on amg_pkg and the affine_transform_matrix_generator RTL only.
module affine_transform_matrix_generator_tb;
  import amg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int WATCHDOG = 20000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               zax;
    logic               lst;
  } row_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ang;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        known;
    logic [31:0] diag;
    logic        zax;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] op = '0;
  logic signed [31:0] angle = '0, val_x = '0, val_y = '0, val_z = '0;
  logic busy, row_valid, zero_axis, last_row;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;

  row_t expected_rows[$];
  int errors = 0;
  int rows_seen = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int items_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  affine_transform_matrix_generator #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .angle(angle),
    .val_x(val_x), .val_y(val_y), .val_z(val_z), .row_valid(row_valid),
    .row_index(row_index), .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .zero_axis(zero_axis), .last_row(last_row)
  );

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sat(longint v, int frac);
    longint r;
    r = asr(v + (64'sd1 <<< (frac - 1)), frac);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint atan_step(int i);
    return longint'(atan_q30(5'(i)));
  endfunction

  task automatic sin_cos(input longint ang16, output longint c, output longint s);
    longint r, x, y, nx;
    bit flip;
    r = (ang16 * 16384) % TWO_PI_Q30;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (r < 0) r += TWO_PI_Q30;
    if (r > PI_Q30) r -= TWO_PI_Q30;
    if (r > HALF_PI_Q30) begin
      r = PI_Q30 - r;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r = -PI_Q30 - r;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 30; i++) begin
      if (r >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        r -= atan_step(i);
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        r += atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_axis(longint v, longint unsigned len);
    longint unsigned mag, q;
    mag = v < 0 ? longint'(-v) : longint'(v);
    q = ((mag << 30) + (len >> 1)) / len;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return asr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  task automatic predict_matrix(input logic [2:0] code, input logic signed [31:0] ang,
                                input logic signed [31:0] vx, input logic signed [31:0] vy,
                                input logic signed [31:0] vz);
    longint m[4][4];
    longint c30, s30, c, s, ux, uy, uz, t, cq, xx, yy, zz, xy, xz, yz;
    longint unsigned ax, ay, az, sum, len;
    logic zax;
    row_t r;
    zax = 1'b0;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 4; k++) m[i][k] = (i == k) ? 65536 : 0;
    sin_cos(longint'(ang), c30, s30);
    c = round_sat(c30, 14);
    s = round_sat(s30, 14);
    case (code)
      OP_TRANSLATE: begin
        m[0][3] = vx; m[1][3] = vy; m[2][3] = vz;
      end
      OP_SCALE: begin
        m[0][0] = vx; m[1][1] = vy; m[2][2] = vz;
      end
      OP_ROT_X: begin
        m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
      end
      OP_ROT_Y: begin
        m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
      end
      OP_ROT_Z: begin
        m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
      end
      OP_AXIS: begin
        ax = vx < 0 ? -longint'(vx) : longint'(vx);
        ay = vy < 0 ? -longint'(vy) : longint'(vy);
        az = vz < 0 ? -longint'(vz) : longint'(vz);
        sum = ax * ax + ay * ay + az * az;
        if (sum == 0) begin
          zax = 1'b1;
        end else begin
          len = int_sqrt(sum);
          ux = unit_axis(vx, len);
          uy = unit_axis(vy, len);
          uz = unit_axis(vz, len);
          t = ONE_Q30 - c30;
          xx = mulq(ux, ux); yy = mulq(uy, uy); zz = mulq(uz, uz);
          xy = mulq(ux, uy); xz = mulq(ux, uz); yz = mulq(uy, uz);
          cq = c30 * ONE_Q30;
          m[0][0] = round_sat(xx * t + cq, 44);
          m[0][1] = round_sat(xy * t - uz * s30, 44);
          m[0][2] = round_sat(xz * t + uy * s30, 44);
          m[1][0] = round_sat(xy * t + uz * s30, 44);
          m[1][1] = round_sat(yy * t + cq, 44);
          m[1][2] = round_sat(yz * t - ux * s30, 44);
          m[2][0] = round_sat(xz * t - uy * s30, 44);
          m[2][1] = round_sat(yz * t + ux * s30, 44);
          m[2][2] = round_sat(zz * t + cq, 44);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      r.idx = 2'(i);
      r.c0 = m[i][0][31:0];
      r.c1 = m[i][1][31:0];
      r.c2 = m[i][2][31:0];
      r.c3 = m[i][3][31:0];
      r.zax = zax;
      r.lst = (i == 3);
      expected_rows.push_back(r);
    end
  endtask

  // Checks rows whose diagonal is typed in by hand against the predicted ones.
  task automatic check_typed(input int base, input logic [31:0] diag, input logic zax);
    for (int i = 0; i < 4; i++) begin
      if (expected_rows[base + i].zax !== zax ||
          (i < 3 && (i == 0 ? expected_rows[base].c0 : i == 1 ?
            expected_rows[base + 1].c1 : expected_rows[base + 2].c2) !== diag)) begin
        $display("%0t: typed row %0d expected diagonal %h zero_axis %b disagrees with prediction",
                 $time, i, diag, zax);
        errors++;
      end
    end
  endtask

  task automatic send_item(input logic [2:0] code, input logic [31:0] ang,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= code;
    angle <= ang;
    val_x <= vx;
    val_y <= vy;
    val_z <= vz;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_matrix(code, ang, vx, vy, vz);
    items_sent++;
  endtask

  always @(posedge clk) begin
    row_t e;
    if (!rst && row_valid) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row %0d cols %h %h %h %h", $time, row_index,
                 col0, col1, col2, col3);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (row_index !== e.idx || col0 !== e.c0 || col1 !== e.c1 || col2 !== e.c2 ||
            col3 !== e.c3 || zero_axis !== e.zax || last_row !== e.lst) begin
          $display("%0t: expected row %0d %h %h %h %h z%b l%b, got row %0d %h %h %h %h z%b l%b",
                   $time, e.idx, e.c0, e.c1, e.c2, e.c3, e.zax, e.lst,
                   row_index, col0, col1, col2, col3, zero_axis, last_row);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || row_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired with %0d rows outstanding", $time,
               expected_rows.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  cmd_row_t directed[$];

  initial begin
    int base, phase_items;
    logic [2:0] code;
    logic [31:0] vx, vy, vz;
    directed = '{
      '{OP_TRANSLATE, 32'h0, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 1'b1, 32'h1_0000, 1'b0},
      '{OP_TRANSLATE, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1, 32'h1_0000, 1'b0},
      '{OP_SCALE, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_SCALE, 32'hffff_ffff, 32'h0002_0000, 32'h0, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_X, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_X, 32'h0001_921f, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_Y, 32'h0003_243f, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_Y, 32'hfffc_dbc1, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_Z, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_ROT_Z, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b1, 32'h1_0000, 1'b1},
      '{OP_AXIS, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'hfffe_0000, 32'h0, 32'hffff_0000, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'h0000_c000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'h0002_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b0, 32'h0, 1'b0},
      '{OP_AXIS, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 32'h0, 1'b0},
      '{OP_SPARE_A, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h1_0000, 1'b0},
      '{OP_SPARE_B, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 1'b1, 32'h1_0000, 1'b0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].ang, directed[i].vx, directed[i].vy,
                directed[i].vz);
      base = expected_rows.size() - 4;
      if (directed[i].known) check_typed(base, directed[i].diag, directed[i].zax);
    end
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 81 : (ph == 2) ? 25 : 0;
      phase_items = (ph == 3) ? 35 : 40;
      for (int n = 0; n < phase_items; n++) begin
        code = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        vx = rand_field();
        vy = rand_field();
        vz = rand_field();
        if (code == OP_AXIS && $urandom_range(11) == 0) begin
          vx = 0; vy = 0; vz = 0;
        end
        send_item(code, rand_field(), vx, vy, vz);
      end
    end
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (STEPS + 200) @(posedge clk);
    $display("Sent %0d transactions over four idling phases, checked %0d rows.",
             items_sent, rows_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/amg_pkg.sv
hdl/amg_front.sv
hdl/amg_back.sv
hdl/affine_transform_matrix_generator.sv
hdl/amg_checker.sv
tb/sv/affine_transform_matrix_generator_tb.sv
